// File: rtl/core/heater_mode_controller_defines.svh
// Assertion macros for the heater mode controller checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef HEATER_MODE_CONTROLLER_DEFINES_SVH
`define HEATER_MODE_CONTROLLER_DEFINES_SVH

// Checked property, ignored while reset is held.
`define HMC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define HMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hmc_pkg.sv
// Shared types and constants for the heater mode controller.
// No dependencies.
package hmc_pkg;

  localparam int TIME_W = 32;  // width of the millisecond time base
  localparam int TGT_W  = 10;
  localparam int WIN_W  = 16;
  localparam int DRV_W  = 16;
  localparam int KNOB_W = 10;
  localparam int PROD_W = KNOB_W + WIN_W;

  localparam logic [TGT_W-1:0] TARGET_MAX   = TGT_W'(848);
  localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(600);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5000);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_ENC    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_CONFIG = 2'd1,
    MODE_HEATER = 2'd2,
    MODE_BOIL   = 2'd3
  } mode_t;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now_ms;
    logic              enc_a;
    logic              enc_b;
    logic [DRV_W-1:0]  drive;
    logic [KNOB_W-1:0] knob;
  } in_item_t;

  typedef struct packed {
    logic             heater_on;
    mode_t            mode;
    logic [TGT_W-1:0] target_quarters;
    logic             blink;
  } out_item_t;

  // Request held in the input register, with the boil duty product
  // precomputed so the main stage only compares.
  typedef struct packed {
    logic              valid;
    in_item_t          item;
    logic [PROD_W-1:0] duty_prod;
  } stage_t;

endpackage

// File: rtl/core/hmc_in_stage.sv
// Input register of the heater mode controller.
// Depends on hmc_pkg.
module hmc_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hmc_pkg::in_item_t             in_data,
  input  logic [hmc_pkg::WIN_W-1:0]     window_size,
  input  logic                          advance,
  output hmc_pkg::stage_t               stage
);

  hmc_pkg::stage_t stage_next;

  assign in_ready = !stage.valid || advance;

  always_comb begin
    stage_next = stage;
    if (in_ready) begin
      stage_next.valid     = in_valid;
      stage_next.item      = in_data;
      // knob * window, so the boil test needs no multiply later
      stage_next.duty_prod = hmc_pkg::PROD_W'(in_data.knob) * hmc_pkg::PROD_W'(window_size);
    end
  end

  always_ff @(posedge clk) begin
    stage.item      <= stage_next.item;
    stage.duty_prod <= stage_next.duty_prod;
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
  end

endmodule

// File: rtl/core/hmc_core.sv
// Mode, target, blink and heater state with their next-state logic.
// Depends on hmc_pkg.
module hmc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  hmc_pkg::stage_t               stage,
  input  logic [hmc_pkg::WIN_W-1:0]     window_size,
  output hmc_pkg::out_item_t            result
);

  localparam logic [hmc_pkg::TIME_W-1:0] SECOND_MS   = hmc_pkg::TIME_W'(1000);
  localparam logic [hmc_pkg::TIME_W-1:0] DEBOUNCE_MS = hmc_pkg::TIME_W'(200);

  // quadrature history codes
  localparam logic [3:0] ENC_UP0 = 4'b1101;
  localparam logic [3:0] ENC_UP1 = 4'b0100;
  localparam logic [3:0] ENC_UP2 = 4'b0010;
  localparam logic [3:0] ENC_UP3 = 4'b1011;
  localparam logic [3:0] ENC_DN0 = 4'b1110;
  localparam logic [3:0] ENC_DN1 = 4'b0111;
  localparam logic [3:0] ENC_DN2 = 4'b0001;
  localparam logic [3:0] ENC_DN3 = 4'b1000;

  hmc_pkg::mode_t              mode_reg,     mode_reg_next;
  logic [hmc_pkg::TGT_W-1:0]   target_reg,   target_reg_next;
  logic [3:0]                  enc_history,  enc_history_next;
  logic [hmc_pkg::TIME_W-1:0]  second_mark,  second_mark_next;
  logic [hmc_pkg::TIME_W-1:0]  window_start, window_start_next;
  logic [hmc_pkg::TIME_W-1:0]  button_mark,  button_mark_next;
  logic                        heater_reg,   heater_reg_next;
  logic                        blink_reg,    blink_reg_next;

  logic [hmc_pkg::TIME_W-1:0]  now;
  logic [hmc_pkg::TIME_W-1:0]  el_sec, el_win, el_btn;
  logic                        win_restart;
  logic [hmc_pkg::WIN_W-1:0]   win_el;
  logic [hmc_pkg::PROD_W-1:0]  win_el_scaled;
  logic [3:0]                  hist;

  assign now    = stage.item.now_ms;
  assign el_sec = now - second_mark;
  assign el_win = now - window_start;
  assign el_btn = now - button_mark;

  // window restarts once elapsed passes its length; elapsed then reads zero
  assign win_restart   = el_win > hmc_pkg::TIME_W'(window_size);
  assign win_el        = win_restart ? '0 : el_win[hmc_pkg::WIN_W-1:0];
  assign win_el_scaled = {win_el, 10'b0} - hmc_pkg::PROD_W'(win_el);  // 1023 * elapsed
  assign hist          = {enc_history[1:0], stage.item.enc_b, stage.item.enc_a};

  always_comb begin
    mode_reg_next     = mode_reg;
    target_reg_next   = target_reg;
    enc_history_next  = enc_history;
    second_mark_next  = second_mark;
    window_start_next = window_start;
    button_mark_next  = button_mark;
    heater_reg_next   = heater_reg;
    blink_reg_next    = blink_reg;
    case (stage.item.op)
      hmc_pkg::OP_TICK: begin
        if (mode_reg != hmc_pkg::MODE_CONFIG && el_sec >= SECOND_MS) begin
          second_mark_next = now;
          if (mode_reg == hmc_pkg::MODE_START) begin
            blink_reg_next = !blink_reg;
          end else begin
            if (win_restart) begin
              window_start_next = now;
            end
            if (mode_reg == hmc_pkg::MODE_HEATER) begin
              heater_reg_next = stage.item.drive > win_el;
            end else begin
              heater_reg_next = stage.duty_prod > win_el_scaled;
            end
          end
        end
      end
      hmc_pkg::OP_BUTTON: begin
        button_mark_next = now;
        if (el_btn > DEBOUNCE_MS) begin
          case (mode_reg)
            hmc_pkg::MODE_START: begin
              mode_reg_next = hmc_pkg::MODE_CONFIG;
            end
            hmc_pkg::MODE_CONFIG: begin
              window_start_next = now;
              mode_reg_next     = hmc_pkg::MODE_HEATER;
            end
            hmc_pkg::MODE_HEATER: begin
              heater_reg_next = 1'b0;
              mode_reg_next   = hmc_pkg::MODE_BOIL;
            end
            default: begin
              heater_reg_next = 1'b0;
              mode_reg_next   = hmc_pkg::MODE_START;
            end
          endcase
        end
      end
      hmc_pkg::OP_ENC: begin
        if (mode_reg == hmc_pkg::MODE_CONFIG) begin
          enc_history_next = hist;
          if (hist == ENC_UP0 || hist == ENC_UP1 || hist == ENC_UP2 || hist == ENC_UP3) begin
            target_reg_next = (target_reg >= hmc_pkg::TARGET_MAX) ? '0 : target_reg + 1'b1;
          end else if (hist == ENC_DN0 || hist == ENC_DN1 || hist == ENC_DN2 ||
                       hist == ENC_DN3) begin
            target_reg_next = (target_reg == '0) ? hmc_pkg::TARGET_MAX : target_reg - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= hmc_pkg::MODE_START;
      target_reg   <= hmc_pkg::TARGET_RESET;
      enc_history  <= '0;
      second_mark  <= '0;
      window_start <= '0;
      button_mark  <= '0;
      heater_reg   <= 1'b0;
      blink_reg    <= 1'b0;
    end else if (advance) begin
      mode_reg     <= mode_reg_next;
      target_reg   <= target_reg_next;
      enc_history  <= enc_history_next;
      second_mark  <= second_mark_next;
      window_start <= window_start_next;
      button_mark  <= button_mark_next;
      heater_reg   <= heater_reg_next;
      blink_reg    <= blink_reg_next;
    end
  end

  assign result.heater_on       = heater_reg_next;
  assign result.mode            = mode_reg_next;
  assign result.target_quarters = target_reg_next;
  assign result.blink           = blink_reg_next;

endmodule

// File: rtl/core/hmc_out_stage.sv
// Result register of the heater mode controller.
// Depends on hmc_pkg.
module hmc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hmc_pkg::out_item_t result,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output hmc_pkg::out_item_t out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

endmodule

// File: rtl/core/heater_mode_controller.sv
// Top level of the heater mode controller: input register, state core,
// result register and the window length register.
// Depends on hmc_pkg, hmc_in_stage, hmc_core, hmc_out_stage.
//
// Usage:
//  - in_valid/in_ready/in_data carry one request: a time tick, a button
//    rising edge or an encoder sample, with time, drive and knob fields.
//  - out_valid/out_ready/out_data return exactly one result per request:
//    heater level, mode, target in quarter degrees and blink phase, all
//    as they stand after that request.
//  - cfg_valid/cfg_ready/cfg_data write the window length in ms. cfg_ready
//    is always high; write only while no request is in flight.
//  - Path: an accepted request is held in the input register, then loaded
//    into the result register once that has room, which raises out_valid
//    until the receiver takes the result.
//  - Throughput: one request per cycle while out_ready stays high. The state
//    core updates per request, so each sees the state left by the one before it.
//  - Receiver stall: the result register holds its result; the input
//    register takes one more request only if empty, then in_ready stays low until
//    out_ready returns.
//  - Reset (rst, synchronous): start mode, target 600, heater off, blink
//    low, all time marks zero, window length 5000 ms, both registers empty.
module heater_mode_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hmc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hmc_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hmc_pkg::WIN_W-1:0] cfg_data
);

  logic [hmc_pkg::WIN_W-1:0] window_size;
  hmc_pkg::stage_t           stage;
  hmc_pkg::out_item_t        result;
  logic                      can_load;
  logic                      advance;

  // Window length register; config is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= hmc_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      window_size <= cfg_data;
    end
  end

  // A held request moves into the result register whenever that has room.
  assign advance = stage.valid && can_load;

  hmc_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .window_size (window_size),
    .advance     (advance),
    .stage       (stage)
  );

  hmc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .stage       (stage),
    .window_size (window_size),
    .result      (result)
  );

  hmc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/hmc_checker.sv
// Port-level checks for the heater mode controller, bound to the top level.
// Depends on hmc_pkg and heater_mode_controller_defines.svh.
`include "heater_mode_controller_defines.svh"

module hmc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input hmc_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input logic                      out_ready,
  input hmc_pkg::out_item_t        out_data,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [hmc_pkg::WIN_W-1:0] cfg_data
);

  `HMC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result shown right after reset")

  `HMC_ASSERT(a_target_range, clk, rst, out_valid |-> out_data.target_quarters <= hmc_pkg::TARGET_MAX, "target out of range")

  `HMC_ASSERT(a_heater_mode, clk, rst, (out_valid && out_data.heater_on) |-> (out_data.mode == hmc_pkg::MODE_HEATER || out_data.mode == hmc_pkg::MODE_BOIL), "heater on outside heater or boil mode")

  `HMC_ASSERT(a_stall_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed")

endmodule

bind heater_mode_controller hmc_checker u_hmc_checker (.*);

// File: sim/tb_heater_mode_controller.sv
// Testbench for heater_mode_controller: directed table, then random requests over several
// window lengths. Each result is checked against a hand-worked status or a local model.
// Depends on hmc_pkg and the heater_mode_controller RTL; needs no files or arguments.
module tb_heater_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import hmc_pkg::*;

  // Cycles with no handshake on any channel before the run is declared hung. The worst
  // legal quiet stretch is the longest sender gap or receiver stall plus the pipeline,
  // so this is many times over.
  localparam int STALL_LIMIT = 2000;
  localparam int MIX_QUOTA   = 310;  // counted requests per random phase

  // Quadrature history codes: {previous b,a, current b,a}.
  localparam logic [3:0] ENC_UP_0 = 4'b1101;
  localparam logic [3:0] ENC_UP_1 = 4'b0100;
  localparam logic [3:0] ENC_UP_2 = 4'b0010;
  localparam logic [3:0] ENC_UP_3 = 4'b1011;
  localparam logic [3:0] ENC_DN_0 = 4'b1110;
  localparam logic [3:0] ENC_DN_1 = 4'b0111;
  localparam logic [3:0] ENC_DN_2 = 4'b0001;
  localparam logic [3:0] ENC_DN_3 = 4'b1000;

  typedef struct {
    in_item_t  req;
    bit        typed;  // want holds a hand-worked status
    out_item_t want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIN_W-1:0] cfg_data = '0;

  heater_mode_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local copy of the controller state, at reset values.
  // ---------------------------------------------------------------------------
  mode_t             mode_q    = MODE_START;
  logic [TGT_W-1:0]  target_q  = TARGET_RESET;
  logic [3:0]        pins_hist = 4'd0;
  logic [TIME_W-1:0] sec_mark  = '0;
  logic [TIME_W-1:0] win_start = '0;
  logic [TIME_W-1:0] btn_mark  = '0;
  logic              heat_q    = 1'b0;
  logic              blink_q   = 1'b0;
  logic [WIN_W-1:0]  win_len   = WINDOW_RESET;

  out_item_t         status_due[$];  // statuses still owed by the DUT, oldest first
  out_item_t         want_r;
  int                mismatches   = 0;
  int                counted_reqs = 0;  // requests other than no-ops and stray encoder samples
  int                quiet_cycles = 0;
  bit                steady_in    = 1'b0;  // sender runs without gaps for this episode
  logic [TIME_W-1:0] wall_ms;

  // Apply one request to the local state and return the status that follows it.
  function automatic out_item_t advance_controller(input in_item_t r);
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] into_win;
    logic [3:0]        hist;
    out_item_t         res;
    case (r.op)
      OP_TICK: begin
        since = r.now_ms - sec_mark;
        // Configure mode freezes the one-second tick entirely.
        if (mode_q != MODE_CONFIG && since >= 32'd1000) begin
          if (mode_q == MODE_START) begin
            blink_q = ~blink_q;
          end else begin
            into_win = r.now_ms - win_start;
            if (into_win > {16'd0, win_len}) begin
              win_start = r.now_ms;
            end
            into_win = r.now_ms - win_start;
            if (mode_q == MODE_HEATER) begin
              heat_q = ({16'd0, r.drive} > into_win);
            end else begin
              // knob*window/1023 > elapsed, kept exact by cross-multiplying
              heat_q = (64'(r.knob) * 64'(win_len) > 64'(into_win) * 64'd1023);
            end
          end
          sec_mark = r.now_ms;
        end
      end
      OP_BUTTON: begin
        // Debounce: a press within 200 ms of the last one is dropped but still
        // moves the mark.
        if (r.now_ms - btn_mark > 32'd200) begin
          case (mode_q)
            MODE_START: mode_q = MODE_CONFIG;
            MODE_CONFIG: begin
              win_start = r.now_ms;
              mode_q    = MODE_HEATER;
            end
            MODE_HEATER: begin
              heat_q = 1'b0;
              mode_q = MODE_BOIL;
            end
            default: begin
              heat_q = 1'b0;
              mode_q = MODE_START;
            end
          endcase
        end
        btn_mark = r.now_ms;
      end
      OP_ENC: begin
        if (mode_q == MODE_CONFIG) begin
          hist      = {pins_hist[1:0], r.enc_b, r.enc_a};
          pins_hist = hist;
          if (hist inside {ENC_UP_0, ENC_UP_1, ENC_UP_2, ENC_UP_3}) begin
            target_q = (target_q >= TARGET_MAX) ? '0 : target_q + 1'b1;
          end else if (hist inside {ENC_DN_0, ENC_DN_1, ENC_DN_2, ENC_DN_3}) begin
            target_q = (target_q == '0) ? TARGET_MAX : target_q - 1'b1;
          end
        end
      end
      default: ;  // OP_NONE leaves everything alone
    endcase
    res.heater_on       = heat_q;
    res.mode            = mode_q;
    res.target_quarters = target_q;
    res.blink           = blink_q;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sender gap: mostly back to back, some short pauses, a few long ones.
  function automatic int pick_gap();
    int dice;
    if (steady_in) return 0;
    dice = $urandom_range(0, 99);
    if (dice < 60) return 0;
    if (dice < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request, wait for the handshake, then record what it should produce.
  task automatic send_req(input in_item_t r, input bit typed, input out_item_t want);
    int        gap;
    out_item_t model_out;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    // Stray encoder samples and no-ops are only noise.
    if (!(r.op == OP_NONE || (r.op == OP_ENC && mode_q != MODE_CONFIG))) begin
      counted_reqs++;
    end
    model_out = advance_controller(r);
    status_due.push_back(typed ? want : model_out);
  endtask

  // Random request at time t; drive is mostly kept near the window so both heater
  // levels show up.
  function automatic in_item_t make_req(input op_t op, input logic [TIME_W-1:0] t);
    in_item_t r;
    int       span;
    span = int'(win_len) + int'(win_len) / 4;
    if (span > 65535) span = 65535;
    r.op     = op;
    r.now_ms = t;
    r.enc_a  = 1'($urandom_range(0, 1));
    r.enc_b  = 1'($urandom_range(0, 1));
    r.drive  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
    r.knob   = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  // Walk the encoder a number of detents in one direction, with the odd glitch.
  task automatic turn_knob(input int steps, input bit up);
    in_item_t   r;
    logic [1:0] pins;
    repeat (steps) begin
      pins = pins_hist[1:0];  // {b,a} as last seen in configure mode
      if (up) begin
        case (pins)
          2'b00:   pins = 2'b10;
          2'b10:   pins = 2'b11;
          2'b11:   pins = 2'b01;
          default: pins = 2'b00;
        endcase
      end else begin
        case (pins)
          2'b00:   pins = 2'b01;
          2'b01:   pins = 2'b11;
          2'b11:   pins = 2'b10;
          default: pins = 2'b00;
        endcase
      end
      if ($urandom_range(0, 19) == 0) pins = 2'($urandom_range(0, 3));
      r       = make_req(OP_ENC, wall_ms);
      r.enc_b = pins[1];
      r.enc_a = pins[0];
      send_req(r, 1'b0, '0);
    end
  endtask

  task automatic tick_after(input logic [TIME_W-1:0] adv);
    wall_ms = wall_ms + adv;
    send_req(make_req(OP_TICK, wall_ms), 1'b0, '0);
  endtask

  // Random mix of episodes until the phase quota of counted requests is reached.
  task automatic run_mix(input int quota);
    int base;
    int dice;
    int n;
    base = counted_reqs;
    while (counted_reqs - base < quota) begin
      steady_in = ($urandom_range(0, 6) == 0);
      dice      = $urandom_range(0, 99);
      if (dice < 40) begin
        // burst of ticks, mostly a second or so apart, sometimes a long leap
        n = $urandom_range(1, 8);
        repeat (n) begin
          tick_after(($urandom_range(0, 99) < 85) ? $urandom_range(0, 1500)
                                                  : $urandom_range(1500, 70000));
        end
      end else if (dice < 60) begin
        // button: about half land inside the debounce window
        wall_ms = wall_ms + $urandom_range(0, 400);
        send_req(make_req(OP_BUTTON, wall_ms), 1'b0, '0);
      end else if (dice < 85) begin
        if (mode_q == MODE_CONFIG) begin
          turn_knob($urandom_range(1, 40), 1'($urandom_range(0, 1)));
        end else begin
          send_req(make_req(OP_ENC, wall_ms), 1'b0, '0);
        end
      end else if (dice < 89) begin
        // long turn toward the nearer end so the target wraps around, or a tick outside configure
        if (mode_q != MODE_CONFIG) begin
          tick_after($urandom_range(0, 1500));
        end else if (target_q >= 10'd424) begin
          turn_knob(int'(TARGET_MAX) + 1 - int'(target_q) + $urandom_range(1, 12), 1'b1);
        end else begin
          turn_knob(int'(target_q) + $urandom_range(1, 12), 1'b0);
        end
      end else if (dice < 94) begin
        send_req(make_req(OP_NONE, 32'($urandom)), 1'b0, '0);
      end else begin
        // jump anywhere on the 32-bit time line, wrap included
        wall_ms = 32'($urandom);
        tick_after(32'd0);
      end
    end
    steady_in = 1'b0;
  endtask

  // Window writes only with nothing in flight.
  task automatic set_window(input logic [WIN_W-1:0] len);
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    win_len = len;
    cfg_valid <= 1'b0;
  endtask

  function automatic out_item_t status(input logic heat, input mode_t m,
                                       input logic [TGT_W-1:0] tgt, input logic bl);
    out_item_t s;
    s.heater_on       = heat;
    s.mode            = m;
    s.target_quarters = tgt;
    s.blink           = bl;
    return s;
  endfunction

  function automatic plan_row_t row(input op_t op, input logic [TIME_W-1:0] t,
                                    input logic a, input logic b,
                                    input logic [DRV_W-1:0] drv,
                                    input logic [KNOB_W-1:0] kb,
                                    input bit typed, input out_item_t want);
    plan_row_t p;
    p.req.op     = op;
    p.req.now_ms = t;
    p.req.enc_a  = a;
    p.req.enc_b  = b;
    p.req.drive  = drv;
    p.req.knob   = kb;
    p.typed      = typed;
    p.want       = want;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted status against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        flag_mismatch("result with none due", 32'(out_data), 32'd0);
      end else begin
        want_r = status_due.pop_front();
        if (out_data.heater_on !== want_r.heater_on)
          flag_mismatch("heater_on", 32'(out_data.heater_on), 32'(want_r.heater_on));
        if (out_data.mode !== want_r.mode)
          flag_mismatch("mode", 32'(out_data.mode), 32'(want_r.mode));
        if (out_data.target_quarters !== want_r.target_quarters)
          flag_mismatch("target_quarters", 32'(out_data.target_quarters),
                        32'(want_r.target_quarters));
        if (out_data.blink !== want_r.blink)
          flag_mismatch("blink", 32'(out_data.blink), 32'(want_r.blink));
      end
    end
  end

  // Receiver: ready in runs of random length, stalls mostly short, sometimes long.
  initial begin
    int run_len;
    int hold_len;
    int dice;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      dice = $urandom_range(0, 99);
      hold_len = (dice < 55) ? 0 : (dice < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  // Hang detector: counts cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t        plan[$];
    logic [WIN_W-1:0] win_plan[5];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table, window at its reset length of 5000 ms.
    // Typed rows: reset status, one-second boundary, debounce at 200 vs 201 ms, quadrature
    // codes both ways plus an invalid transition, mode walk, time wrap.
    plan.push_back(row(OP_NONE,   32'd0,     1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_START,  10'd600, 1'b0)));
    plan.push_back(row(OP_TICK,   32'd999,   1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_START,  10'd600, 1'b0)));
    plan.push_back(row(OP_TICK,   32'd1000,  1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_START,  10'd600, 1'b1)));
    // encoder outside configure is ignored
    plan.push_back(row(OP_ENC,    32'd1000,  1'b1, 1'b1, 16'hFFFF,  10'h3FF,  1'b1,
                       status(1'b0, MODE_START,  10'd600, 1'b1)));
    plan.push_back(row(OP_BUTTON, 32'd200,   1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_START,  10'd600, 1'b1)));
    plan.push_back(row(OP_BUTTON, 32'd401,   1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd600, 1'b1)));
    // tick does nothing in configure mode
    plan.push_back(row(OP_TICK,   32'd5000,  1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd600, 1'b1)));
    plan.push_back(row(OP_ENC,    32'd5000,  1'b0, 1'b1, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd601, 1'b1)));
    plan.push_back(row(OP_ENC,    32'd5000,  1'b1, 1'b1, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd602, 1'b1)));
    plan.push_back(row(OP_ENC,    32'd5000,  1'b1, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd603, 1'b1)));
    plan.push_back(row(OP_ENC,    32'd5000,  1'b1, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd603, 1'b1)));
    plan.push_back(row(OP_ENC,    32'd5000,  1'b1, 1'b1, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_CONFIG, 10'd602, 1'b1)));
    plan.push_back(row(OP_BUTTON, 32'd700,   1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_HEATER, 10'd602, 1'b1)));
    // heater mode: drive extremes, exact window edge, window restart
    plan.push_back(row(OP_TICK,   32'd2000,  1'b0, 1'b0, 16'hFFFF,  10'd0,    1'b0, '0));
    plan.push_back(row(OP_TICK,   32'd3000,  1'b0, 1'b0, 16'd0,     10'd0,    1'b0, '0));
    plan.push_back(row(OP_TICK,   32'd5700,  1'b0, 1'b0, 16'd5000,  10'd0,    1'b0, '0));
    plan.push_back(row(OP_TICK,   32'd6701,  1'b0, 1'b0, 16'd1,     10'd0,    1'b0, '0));
    plan.push_back(row(OP_BUTTON, 32'd7000,  1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_BOIL,   10'd602, 1'b1)));
    // boil mode: knob extremes and the duty comparison one step either side
    plan.push_back(row(OP_TICK,   32'd7701,  1'b0, 1'b0, 16'd0,     10'h3FF,  1'b0, '0));
    plan.push_back(row(OP_TICK,   32'd8701,  1'b0, 1'b0, 16'd0,     10'd0,    1'b0, '0));
    plan.push_back(row(OP_TICK,   32'd9701,  1'b0, 1'b0, 16'd0,     10'd614,  1'b0, '0));
    plan.push_back(row(OP_TICK,   32'd10701, 1'b0, 1'b0, 16'd0,     10'd818,  1'b0, '0));
    plan.push_back(row(OP_BUTTON, 32'd10800, 1'b0, 1'b0, 16'd0,     10'd0,    1'b1,
                       status(1'b0, MODE_START,  10'd602, 1'b1)));
    // top of the time line, then across the wrap
    plan.push_back(row(OP_TICK,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 10'd0,    1'b1,
                       status(1'b0, MODE_START,  10'd602, 1'b0)));
    plan.push_back(row(OP_TICK,   32'd999,   1'b0, 1'b0, 16'd0,     10'd0,    1'b0, '0));

    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);

    // Random phases: one-ms and longest window, the zero window, then two others.
    win_plan[0] = 16'd1;
    win_plan[1] = 16'hFFFF;
    win_plan[2] = 16'd0;
    win_plan[3] = 16'($urandom_range(2, 65534));
    win_plan[4] = 16'($urandom_range(100, 3000));
    wall_ms = 32'd999;
    foreach (win_plan[k]) begin
      set_window(win_plan[k]);
      run_mix(MIX_QUOTA);
    end

    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // catch any extra result still in the registers

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
